FILE: hdl/double_ended_queue_macros.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared property templates for the queue's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define DQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held.
`define DQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared constants, request and status codes, controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

    localparam int DQ_DEPTH  = 32;
    localparam int DQ_DATA_W = 32;
    localparam int DQ_REQ_W  = 3;
    localparam int DQ_USER_W = 3;   // has_element + status

    typedef enum logic [DQ_REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_SHOW_FWD   = 3'd4,
        REQ_SHOW_BWD   = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    push;
        logic    push_front;
        logic    pop;
        logic    pop_front;
        logic    walk_start;
        logic    walk_back;
        logic    walk_step;
        logic    resp_load;
        t_status resp_status;
    } t_dq_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic walk_last;
        logic out_free;
    } t_dq_stat;

endpackage

`default_nettype wire

FILE: hdl/dq_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Decodes requests into datapath commands and sequences read-outs.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [dq_pkg::DQ_REQ_W-1:0]   i_req,
    input  wire dq_pkg::t_dq_stat              i_stat,
    output logic                               o_in_ready,
    output dq_pkg::t_dq_cmd                    o_cmd
);

    import dq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SHOW = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.resp_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_req'(i_req))
                        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                            o_cmd.resp_load = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.resp_status = ST_FULL;
                            end else begin
                                o_cmd.push       = 1'b1;
                                o_cmd.push_front = (t_req'(i_req) == REQ_PUSH_FRONT);
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK: begin
                            o_cmd.resp_load = 1'b1;
                            if (i_stat.empty) begin
                                o_cmd.resp_status = ST_EMPTY;
                            end else begin
                                o_cmd.pop       = 1'b1;
                                o_cmd.pop_front = (t_req'(i_req) == REQ_POP_FRONT);
                            end
                        end
                        REQ_SHOW_FWD, REQ_SHOW_BWD: begin
                            if (i_stat.empty) begin
                                o_cmd.resp_load   = 1'b1;
                                o_cmd.resp_status = ST_EMPTY;
                            end else begin
                                o_cmd.walk_start = 1'b1;
                                o_cmd.walk_back  = (t_req'(i_req) == REQ_SHOW_BWD);
                                n_state          = S_SHOW;
                            end
                        end
                        default: begin
                            // unused codes: a single plain ok result
                            o_cmd.resp_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SHOW: begin
                if (i_stat.out_free) begin
                    o_cmd.walk_step = 1'b1;
                    if (i_stat.walk_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dq_dpath.sv
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring pointers, slot RAM, read-out walker and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_macros.svh"

module dq_dpath #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [dq_pkg::DQ_DATA_W-1:0]  i_item_value,
    input  wire dq_pkg::t_dq_cmd               i_cmd,
    output dq_pkg::t_dq_stat                   o_stat,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [dq_pkg::DQ_DATA_W-1:0]       o_out_value,
    output logic [dq_pkg::DQ_USER_W-1:0]       o_out_user,
    output logic                               o_out_last
);

    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0] DEPTH_X = (AW+1)'(DEPTH);

    // slot index of base + off, wrapped once (both below DEPTH)
    function automatic logic [AW-1:0] f_ring(logic [AW-1:0] base, logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[AW-1:0];
    endfunction

    logic [AW-1:0]        r_front, n_front;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_off;
    logic [CW-1:0]        r_left;
    logic                 r_back;
    logic                 r_out_valid;
    logic [DQ_DATA_W-1:0] r_out_value;
    logic                 r_out_has;
    t_status              r_out_status;
    logic                 r_out_last;

    logic [AW-1:0]        w_front_dec;
    logic [AW-1:0]        w_back_slot;
    logic [AW-1:0]        w_start_off;
    logic [AW-1:0]        w_step_off;
    logic [AW-1:0]        w_rd_off;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_rd_en;
    logic [AW-1:0]        w_wr_addr;
    logic                 w_walk_last;
    logic                 w_out_load;
    logic [DQ_DATA_W-1:0] w_rdata;

    assign w_front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;
    assign w_back_slot = f_ring(r_front, r_count[AW-1:0]);
    assign w_wr_addr   = i_cmd.push_front ? w_front_dec : w_back_slot;

    assign w_walk_last = (r_left == CW'(1));
    assign w_start_off = i_cmd.walk_back ? AW'(r_count - 1'b1) : '0;
    assign w_step_off  = r_back ? r_off - 1'b1 : r_off + 1'b1;
    assign w_rd_off    = i_cmd.walk_start ? w_start_off : w_step_off;
    assign w_rd_addr   = f_ring(r_front, w_rd_off);
    // next read is launched as the current word is taken into the output stage
    assign w_rd_en     = i_cmd.walk_start | (i_cmd.walk_step & ~w_walk_last);

    assign w_out_load  = i_cmd.resp_load | i_cmd.walk_step;

    dq_ram #(
        .WIDTH (DQ_DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (w_wr_addr),
        .i_wdata (i_item_value),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + 1'b1;
            if (i_cmd.push_front) begin
                n_front = w_front_dec;
            end
        end else if (i_cmd.pop) begin
            n_count = r_count - 1'b1;
            if (i_cmd.pop_front) begin
                n_front = f_ring(r_front, AW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_off  <= w_start_off;
            r_left <= r_count;
            r_back <= i_cmd.walk_back;
        end else if (i_cmd.walk_step && !w_walk_last) begin
            r_off  <= w_step_off;
            r_left <= r_left - 1'b1;
        end
        if (i_cmd.walk_step) begin
            r_out_value  <= w_rdata;
            r_out_has    <= 1'b1;
            r_out_status <= ST_OK;
            r_out_last   <= w_walk_last;
        end else if (i_cmd.resp_load) begin
            r_out_value  <= '0;
            r_out_has    <= 1'b0;
            r_out_status <= i_cmd.resp_status;
            r_out_last   <= 1'b1;
        end
    end

    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.walk_last = w_walk_last;
    assign o_stat.out_free  = ~r_out_valid | i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_user  = {r_out_status, r_out_has};
    assign o_out_last  = r_out_last;

    `DQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH),
        "entry count above depth")
    `DQ_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, i_cmd.push, !o_stat.full,
        "push commanded into a full queue")
    `DQ_ASSERT_SAME(a_load_free, i_clk, i_rst_n, w_out_load, o_stat.out_free,
        "output stage overwritten before its transfer")
    `DQ_ASSERT_NEXT(a_walk_count, i_clk, i_rst_n, i_cmd.walk_step && !w_walk_last,
        r_left == $past(r_left) - 1'b1, "read-out counter did not advance")
    `DQ_ASSERT_NEXT(a_resp_last, i_clk, i_rst_n, i_cmd.resp_load,
        r_out_valid && r_out_last && !r_out_has, "single result not marked last")

endmodule

`default_nettype wire

FILE: hdl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit values held in a ring of DEPTH slots.
// ----------------------------------------------------------------------------
// Push, pop and unused request codes each give one result. A show request
// on an empty queue gives one empty result; else it launches the first read
// of the slot RAM, whose read port is registered, then one result leaves
// per cycle while the output is free, each next read overlapping the output
// transfer. Results sit in a single output register: outside a show, a new
// request is taken when that register is empty or in the cycle its waiting
// result transfers, so a stalled output holds off the input. Slots need no
// clearing after reset; the block accepts requests once reset is released.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [dq_pkg::DQ_DATA_W-1:0]  s_axis_tdata,   // [31:0] item_value
    input  wire logic [dq_pkg::DQ_REQ_W-1:0]   s_axis_tuser,   // [2:0] req_type
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [dq_pkg::DQ_DATA_W-1:0]       m_axis_tdata,   // [31:0] out_value
    output logic [dq_pkg::DQ_USER_W-1:0]       m_axis_tuser,   // [0] has_element, [2:1] status
    output logic                               m_axis_tlast
);

    import dq_pkg::*;

    t_dq_cmd  w_cmd;
    t_dq_stat w_stat;

    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req      (s_axis_tuser),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    dq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_value (s_axis_tdata),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_value  (m_axis_tdata),
        .o_out_user   (m_axis_tuser),
        .o_out_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire
